>>> rtl/core/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared constants and types of the lru page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

   localparam int FRAMES     = 8;
   localparam int PAGE_BITS  = 16;
   localparam int SLOT_W     = 3;
   localparam int RANK_W     = 3;
   localparam int CFG_W      = 4;
   localparam int FAULT_W    = 32;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 56;

   localparam logic [RANK_W-1:0] RANK_MAX   = RANK_W'(FRAMES - 1);
   localparam logic [CFG_W-1:0]  CFG_RESET  = CFG_W'(FRAMES);

   // controller to datapath
   typedef struct packed {
      logic load;     // capture the request beat
      logic commit;   // update frames and load the result register
   } cmd_type;

endpackage

>>> rtl/core/lrupr_ctrl.sv
// ----------------------------------------------------------------------------
// lrupr_ctrl
// Sequencer: takes a request beat, then commits it once the result
// register is free, and owns the result valid flag.
// ----------------------------------------------------------------------------
module lrupr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output lrupr_pkg::cmd_type  cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      load, commit;

   always_comb begin
      load   = (state_ff == ST_IDLE) && req_tvalid;
      commit = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (load) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // a commit refills the result register even as the old beat leaves
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign cmd.load   = load;
   assign cmd.commit = commit;

endmodule

>>> rtl/core/lrupr_dp.sv
// ----------------------------------------------------------------------------
// lrupr_dp
// Frame table, recency ranks, fault counter and result register.
// ----------------------------------------------------------------------------
module lrupr_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lrupr_pkg::cmd_type                     cmd,
   input  logic [lrupr_pkg::REQ_DATA_W-1:0]       req_page,
   input  logic                                   csr_we,
   input  logic [lrupr_pkg::CFG_W-1:0]            csr_wdata,
   output logic [lrupr_pkg::RSP_DATA_W-1:0]       rsp_data
);

   logic [lrupr_pkg::PAGE_BITS-1:0] page_ff;
   logic [lrupr_pkg::CFG_W-1:0]     cfg_ff;
   logic [lrupr_pkg::PAGE_BITS-1:0] frame_page_ff [lrupr_pkg::FRAMES];
   logic [lrupr_pkg::FRAMES-1:0]    valid_ff, valid_in;
   logic [lrupr_pkg::RANK_W-1:0]    rank_ff [lrupr_pkg::FRAMES];
   logic [lrupr_pkg::RANK_W-1:0]    rank_in [lrupr_pkg::FRAMES];
   logic [lrupr_pkg::FAULT_W-1:0]   fault_ff, fault_in;

   logic                            hit_ff, evict_ff;
   logic [lrupr_pkg::SLOT_W-1:0]    slot_ff;
   logic [lrupr_pkg::PAGE_BITS-1:0] ev_page_ff, ev_page_in;
   logic [lrupr_pkg::FAULT_W-1:0]   fault_out_ff;

   logic [lrupr_pkg::CFG_W-1:0]     n_eff;
   logic [lrupr_pkg::FRAMES-1:0]    active, match, empty;
   logic                            hit, has_empty, evict;
   logic [lrupr_pkg::SLOT_W-1:0]    hit_slot, empty_slot, victim, slot;
   logic [lrupr_pkg::RANK_W-1:0]    victim_rank;
   logic [lrupr_pkg::RANK_W:0]      old_rank;

   always_comb begin
      priority if (cfg_ff == '0) begin
         n_eff = lrupr_pkg::CFG_W'(1);
      end else if (cfg_ff > lrupr_pkg::CFG_W'(lrupr_pkg::FRAMES)) begin
         n_eff = lrupr_pkg::CFG_W'(lrupr_pkg::FRAMES);
      end else begin
         n_eff = cfg_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < lrupr_pkg::FRAMES; k++) begin
         active[k] = lrupr_pkg::CFG_W'(k) < n_eff;
         match[k]  = active[k] && valid_ff[k] && (frame_page_ff[k] == page_ff);
         empty[k]  = active[k] && !valid_ff[k];
      end
   end

   // lowest-numbered match and lowest-numbered empty frame
   always_comb begin
      hit_slot   = '0;
      empty_slot = '0;
      for (int k = lrupr_pkg::FRAMES - 1; k >= 0; k--) begin
         if (match[k]) begin
            hit_slot = lrupr_pkg::SLOT_W'(k);
         end
         if (empty[k]) begin
            empty_slot = lrupr_pkg::SLOT_W'(k);
         end
      end
      hit       = |match;
      has_empty = |empty;
   end

   // oldest active frame, ties to the lowest index
   always_comb begin
      victim      = '0;
      victim_rank = rank_ff[0];
      for (int k = 1; k < lrupr_pkg::FRAMES; k++) begin
         if (active[k] && (rank_ff[k] > victim_rank)) begin
            victim      = lrupr_pkg::SLOT_W'(k);
            victim_rank = rank_ff[k];
         end
      end
   end

   always_comb begin
      evict = !hit && !has_empty;
      priority if (hit) begin
         slot     = hit_slot;
         old_rank = {1'b0, rank_ff[hit_slot]};
      end else if (has_empty) begin
         slot     = empty_slot;
         // an empty frame counts as older than any rank
         old_rank = (lrupr_pkg::RANK_W + 1)'(lrupr_pkg::FRAMES);
      end else begin
         slot     = victim;
         old_rank = {1'b0, victim_rank};
      end
      ev_page_in = evict ? frame_page_ff[victim] : '0;

      valid_in = valid_ff;
      if (!hit) begin
         valid_in[slot] = 1'b1;
      end

      for (int k = 0; k < lrupr_pkg::FRAMES; k++) begin
         if (lrupr_pkg::SLOT_W'(k) == slot) begin
            rank_in[k] = '0;
         end else if (active[k] && valid_ff[k] && ({1'b0, rank_ff[k]} < old_rank) &&
                      (rank_ff[k] < lrupr_pkg::RANK_MAX)) begin
            rank_in[k] = rank_ff[k] + lrupr_pkg::RANK_W'(1);
         end else begin
            rank_in[k] = rank_ff[k];
         end
      end

      if (hit || (&fault_ff)) begin
         fault_in = fault_ff;
      end else begin
         fault_in = fault_ff + lrupr_pkg::FAULT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= lrupr_pkg::CFG_RESET;
         valid_ff <= '0;
         fault_ff <= '0;
         for (int k = 0; k < lrupr_pkg::FRAMES; k++) begin
            rank_ff[k] <= '0;
         end
      end else begin
         if (csr_we) begin
            cfg_ff <= csr_wdata;
         end
         if (cmd.commit) begin
            valid_ff <= valid_in;
            fault_ff <= fault_in;
            for (int k = 0; k < lrupr_pkg::FRAMES; k++) begin
               rank_ff[k] <= rank_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         page_ff <= req_page;
      end
      if (cmd.commit) begin
         if (!hit) begin
            frame_page_ff[slot] <= page_ff;
         end
         hit_ff       <= hit;
         slot_ff      <= slot;
         evict_ff     <= evict;
         ev_page_ff   <= ev_page_in;
         fault_out_ff <= fault_in;
      end
   end

   assign rsp_data = {3'b000, fault_out_ff, ev_page_ff, evict_ff, slot_ff, hit_ff};

endmodule

>>> rtl/core/lru_page_replacement_top.sv
// ----------------------------------------------------------------------------
// lru_page_replacement_top
// LRU page replacement over eight frames, one result beat per request beat.
// ----------------------------------------------------------------------------
// flow: the request beat is captured, then the frame search, victim pick and
//    rank update share one commit into the result register, stalled while
//    the result is held; no new request is taken until that commit
// reset: synchronous; clears valid marks, ranks and fault count, frame count 8
// ----------------------------------------------------------------------------
module lru_page_replacement_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lrupr_pkg::REQ_DATA_W-1:0]    req_tdata,  // [15:0] page_number
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] hit, [3:1] frame_slot, [4] evicted_valid, [20:5] evicted_page,
   // [52:21] fault_count, [55:53] zero
   output logic [lrupr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                csr_we,
   input  logic [lrupr_pkg::CFG_W-1:0]         csr_wdata   // frames_in_use
);

   lrupr_pkg::cmd_type cmd;

   lrupr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   lrupr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_page  (req_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_tdata)
   );

endmodule

>>> rtl/core/lrupr_chk.sv
// ----------------------------------------------------------------------------
// lrupr_chk
// Port-level checks of the lru page replacement block, bound to the top.
// ----------------------------------------------------------------------------
module lrupr_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [lrupr_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   // no result beat right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat valid after reset");

   // one reference in flight: a taken request blocks the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // a hit never evicts and reports no evicted page
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |->
         (!rsp_tdata[4] && (rsp_tdata[20:5] == 16'h0000)))
      else $error("eviction reported on a hit");

endmodule

bind lru_page_replacement_top lrupr_chk u_lrupr_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
